// ----- rtl/core/brp_pkg.sv -----
// Shared types and constants for the blit request planner.
package brp_pkg;

    localparam int MAX_LINES = 2048;
    localparam int LINE_W = $clog2(MAX_LINES);
    localparam int PITCH_W = 14;
    localparam int OFF_W = 24;
    localparam int COORD_W = 12;
    localparam int QUOT_W = OFF_W;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic CMD_COPY = 1'b0;
    localparam logic CMD_FILL = 1'b1;

    localparam logic [3:0] REG_DISPLAY_PITCH = 4'd0;

    // Classified request handed from the front part to the back part.
    typedef struct packed {
        logic               decline;
        logic               is_fill;
        logic               same_surface;
        logic [PITCH_W-1:0] pitch;
        logic [OFF_W-1:0]   src_offset;
        logic [OFF_W-1:0]   dst_offset;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] dleft;
        logic [COORD_W-1:0] dtop;
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
        logic [15:0]        color;
    } brp_req_t;

    typedef struct packed {
        logic              status;
        logic              is_fill;
        logic [15:0]       start_x;
        logic [LINE_W-1:0] start_y;
        logic [15:0]       target_x;
        logic [LINE_W-1:0] target_y;
        logic [15:0]       width_less_one;
        logic [LINE_W-1:0] height_less_one;
        logic              x_increasing;
        logic              y_increasing;
        logic [15:0]       color_out;
    } brp_res_t;

endpackage

// ----- rtl/core/blit_request_planner.sv -----
// Top level of the blit request planner.
// A request passes through the front register, the queue, the 24-stage offset
// divider and the result register on its way to a result; output stalls and queue
// occupancy can hold it back.
// Throughput: one request per cycle while the output is not stalled; the pipelined pitch divider sets it.
// Reset: synchronous active-low aresetn clears all valid state and the
// display pitch register to zero.
module blit_request_planner (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [0:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: src_pitch, dst_pitch, src_offset, dst_offset, rect_left, rect_top,
    // rect_right, rect_bottom, dest_left, dest_top, fill_color
    input  logic [167:0] s_tdata,
    // tuser: cmd
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: start_x, start_y, target_x, target_y, width_less_one,
    // height_less_one, x_increasing, y_increasing, color_out
    output logic [103:0] m_tdata,
    // tuser: status, is_fill
    output logic [1:0]   m_tuser
);
    import brp_pkg::*;

    logic [PITCH_W-1:0] pitch_reg;
    logic [164:0]       fdata;
    logic               fv, fr, qv, qr;
    brp_req_t           freq, qreq;
    brp_res_t           res;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_DISPLAY_PITCH[0:0]) ? 32'(pitch_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_reg <= '0;
        end else if (psel && penable && pwrite && paddr == REG_DISPLAY_PITCH[0:0]) begin
            pitch_reg <= pwdata[PITCH_W-1:0];
        end
    end

    // Front expects cmd in bit 0, then the tdata fields.
    assign fdata = {s_tdata[163:0], s_tuser};

    brp_front u_front (.aclk, .aresetn, .display_pitch(pitch_reg),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_data(fdata),
        .out_valid(fv), .out_ready(fr), .out_req(freq));

    brp_queue u_queue (.aclk, .aresetn, .in_valid(fv), .in_ready(fr), .in_req(freq),
        .out_valid(qv), .out_ready(qr), .out_req(qreq));

    brp_back u_back (.aclk, .aresetn, .in_valid(qv && qr), .in_ready(qr), .in_req(qreq),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res));

    assign m_tdata = {5'd0, res.color_out, res.y_increasing, res.x_increasing,
        res.height_less_one, res.width_less_one, res.target_y, res.target_x,
        res.start_y, res.start_x};
    assign m_tuser = {res.is_fill, res.status};
endmodule

// ----- rtl/core/brp_front.sv -----
// Front part: checks pitches and the rectangle and classifies each request.
module brp_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [brp_pkg::PITCH_W-1:0] display_pitch,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [164:0]              in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output brp_pkg::brp_req_t         out_req
);
    import brp_pkg::*;

    logic     valid_reg;
    brp_req_t req_reg, req_next;

    logic               cmd;
    logic [PITCH_W-1:0] sp, dp;
    logic [OFF_W-1:0]   so, dof;
    logic [COORD_W-1:0] l, t, r, b, dl, dt;
    logic [15:0]        col;

    assign cmd = in_data[0];
    assign sp  = in_data[14:1];
    assign dp  = in_data[28:15];
    assign so  = in_data[52:29];
    assign dof = in_data[76:53];
    assign l   = in_data[88:77];
    assign t   = in_data[100:89];
    assign r   = in_data[112:101];
    assign b   = in_data[124:113];
    assign dl  = in_data[136:125];
    assign dt  = in_data[148:137];
    assign col = in_data[164:149];

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_req   = req_reg;

    always_comb begin
        logic bad;
        bad = (display_pitch == '0) || (dp != display_pitch) || (r <= l) || (b <= t);
        if (cmd == CMD_COPY && sp != display_pitch) begin
            bad = 1'b1;
        end
        req_next.decline      = bad;
        req_next.is_fill      = (cmd == CMD_FILL);
        req_next.same_surface = (so == dof);
        req_next.pitch        = display_pitch;
        req_next.src_offset   = so;
        req_next.dst_offset   = dof;
        req_next.left         = l;
        req_next.top          = t;
        req_next.dleft        = dl;
        req_next.dtop         = dt;
        req_next.width        = r - l;
        req_next.height       = b - t;
        req_next.color        = col;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            req_reg <= req_next;
        end
    end
endmodule

// ----- rtl/core/brp_queue.sv -----
// Short queue that decouples the front part from the back part.
module brp_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  brp_pkg::brp_req_t in_req,
    output logic              out_valid,
    input  logic              out_ready,
    output brp_pkg::brp_req_t out_req
);
    import brp_pkg::*;

    brp_req_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_reg, rd_reg;
    logic [QPTR_W:0]     cnt_reg;
    logic                push, pop;

    assign in_ready  = (cnt_reg != QDEPTH[QPTR_W:0]);
    assign out_valid = (cnt_reg != '0);
    assign out_req   = mem_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop) rd_reg <= rd_reg + 1'b1;
            if (push && !pop) cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
        if (push) mem_reg[wr_reg] <= in_req;
    end

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg <= QDEPTH)
        else $error("queue count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> !out_valid) else $error("empty queue shows valid");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count missed a push");
endmodule

// ----- rtl/core/brp_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with a remainder-is-zero flag.
module brp_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [brp_pkg::OFF_W-1:0]   dividend,
    input  logic [brp_pkg::PITCH_W-1:0] divisor,
    output logic                        out_valid,
    output logic [brp_pkg::OFF_W-1:0]   quotient,
    output logic                        rem_zero
);
    import brp_pkg::*;

    logic [OFF_W-1:0]   q_reg [OFF_W+1];
    logic [PITCH_W:0]   r_reg [OFF_W+1];
    logic [OFF_W-1:0]   n_reg [OFF_W+1];
    logic [PITCH_W-1:0] d_reg [OFF_W+1];
    logic [OFF_W:0]     v_reg;

    always_comb begin
        q_reg[0] = '0;
        r_reg[0] = '0;
        n_reg[0] = dividend;
        d_reg[0] = divisor;
        v_reg[0] = in_valid;
    end

    for (genvar i = 0; i < OFF_W; i++) begin : g_stage
        logic [PITCH_W+1:0] trial;
        assign trial = {r_reg[i], n_reg[i][OFF_W-1-i]};
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_reg[i];
            end
            if (en) begin
                n_reg[i+1] <= n_reg[i];
                d_reg[i+1] <= d_reg[i];
                if (trial >= {2'b00, d_reg[i]}) begin
                    r_reg[i+1] <= (PITCH_W+1)'(trial - {2'b00, d_reg[i]});
                    q_reg[i+1] <= q_reg[i] | (OFF_W'(1) << (OFF_W-1-i));
                end else begin
                    r_reg[i+1] <= trial[PITCH_W:0];
                    q_reg[i+1] <= q_reg[i];
                end
            end
        end
    end

    assign out_valid = v_reg[OFF_W];
    assign quotient  = q_reg[OFF_W];
    assign rem_zero  = (r_reg[OFF_W] == '0);
endmodule

// ----- rtl/core/brp_back.sv -----
// Back part: divides offsets by the pitch, folds lines into y, picks direction.
module brp_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  brp_pkg::brp_req_t in_req,
    output logic              out_valid,
    input  logic              out_ready,
    output brp_pkg::brp_res_t out_res
);
    import brp_pkg::*;

    localparam int LAT = OFF_W;

    logic     en;
    logic     sv, dv, sz, dz;
    logic [QUOT_W-1:0] sq, dq;
    brp_req_t dly_reg [LAT+1];
    brp_res_t res_reg, res_next;
    logic     res_valid_reg;

    // The pipeline advances whenever the output register can take a result.
    assign en        = !res_valid_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = res_valid_reg;
    assign out_res   = res_reg;

    brp_div u_sdiv (.aclk, .aresetn, .en, .in_valid(in_valid),
        .dividend(in_req.src_offset), .divisor(in_req.pitch),
        .out_valid(sv), .quotient(sq), .rem_zero(sz));
    brp_div u_ddiv (.aclk, .aresetn, .en, .in_valid(in_valid),
        .dividend(in_req.dst_offset), .divisor(in_req.pitch),
        .out_valid(dv), .quotient(dq), .rem_zero(dz));

    always_comb dly_reg[0] = in_req;
    for (genvar i = 0; i < LAT; i++) begin : g_dly
        always_ff @(posedge aclk) if (en) dly_reg[i+1] <= dly_reg[i];
    end

    always_comb begin
        brp_req_t q;
        logic [QUOT_W:0] sy, dy;
        logic s_fit, d_fit, bad;
        logic [16:0] sx, dx;
        q  = dly_reg[LAT];
        sy = {1'b0, sq} + (QUOT_W+1)'(q.top);
        dy = {1'b0, dq} + (QUOT_W+1)'(q.is_fill ? q.top : q.dtop);
        s_fit = (sy < MAX_LINES) && ((QUOT_W+1)'(q.height) <= MAX_LINES - sy);
        d_fit = (dy < MAX_LINES) && ((QUOT_W+1)'(q.height) <= MAX_LINES - dy);
        bad = q.decline || !dz || !d_fit;
        if (!q.is_fill && (!sz || !s_fit)) bad = 1'b1;
        sx = 17'(q.left);
        dx = 17'(q.dleft);
        res_next = '0;
        res_next.status = 1'b1;
        if (!bad) begin
            res_next.status          = 1'b0;
            res_next.is_fill         = q.is_fill;
            res_next.width_less_one  = 16'(q.width) - 16'd1;
            res_next.height_less_one = LINE_W'(q.height - 1'b1);
            res_next.x_increasing    = 1'b1;
            res_next.y_increasing    = 1'b1;
            if (q.is_fill) begin
                res_next.start_x   = 16'(q.left);
                res_next.start_y   = LINE_W'(dy);
                res_next.color_out = q.color;
            end else begin
                if (q.same_surface && dy > sy) begin
                    res_next.y_increasing = 1'b0;
                    sy = sy + (QUOT_W+1)'(q.height) - 1'b1;
                    dy = dy + (QUOT_W+1)'(q.height) - 1'b1;
                end else if (q.same_surface && dy == sy && q.dleft > q.left) begin
                    res_next.x_increasing = 1'b0;
                    sx = sx + 17'(q.width) - 1'b1;
                    dx = dx + 17'(q.width) - 1'b1;
                end
                res_next.start_x  = sx[15:0];
                res_next.start_y  = LINE_W'(sy);
                res_next.target_x = dx[15:0];
                res_next.target_y = LINE_W'(dy);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (en) begin
            res_valid_reg <= dv;
        end
        if (en) res_reg <= res_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn) sv == dv)
        else $error("divider lanes out of step");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && out_res.status) |-> (out_res.is_fill == 1'b0 && out_res.start_x == '0))
        else $error("declined result carries data");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> $stable(out_res))
        else $error("stalled result changed");
endmodule
